// ----- rtl/core/hdpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdpf_pkg
// Shared types and fixed-point constants of the dark pixel filter.
// ----------------------------------------------------------------------------
package hdpf_pkg;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } rsp_type;

   // q0.16 fixed point, one = 1 << 16
   localparam logic [16:0] FX_ONE  = 17'd65536;
   localparam logic [16:0] FX_HALF = 17'd32768;
   localparam logic [15:0] K_BASE  = 16'd3932;
   localparam logic [14:0] K_SPAN  = 15'd31457;
   localparam logic [15:0] K_SAT   = 16'd36045;

   // l = floor((sum * 65536 + 255) * L_RECIP >> L_SHIFT), exact for sum <= 510
   localparam logic [26:0] L_RECIP = 27'd67372037;
   localparam int unsigned L_SHIFT = 35;
   localparam logic [24:0] L_BIAS  = 25'd255;

   // hue in sixths, q3.16
   localparam logic [18:0] H_TWO   = 19'd131072;
   localparam logic [18:0] H_THREE = 19'd196608;
   localparam logic [18:0] H_FOUR  = 19'd262144;
   localparam logic [18:0] H_SIX   = 19'd393216;

   // pipelined restoring divider
   localparam int unsigned DIV_NUM_W  = 24;
   localparam int unsigned DIV_DEN_W  = 8;
   localparam int unsigned DIV_QUO_W  = 18;
   localparam int unsigned DIV_STEPS  = 3;
   localparam int unsigned DIV_STAGES = DIV_QUO_W / DIV_STEPS;

endpackage

// ----- rtl/core/hdpf_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdpf_divider
// Pipelined restoring divider, three quotient bits per stage. The numerator
// must satisfy num < den << DIV_QUO_W.
// ----------------------------------------------------------------------------
module hdpf_divider (
   input  logic                           clock,
   input  logic [hdpf_pkg::DIV_NUM_W-1:0] num,
   input  logic [hdpf_pkg::DIV_DEN_W-1:0] den,
   output logic [hdpf_pkg::DIV_QUO_W-1:0] quo
);
   import hdpf_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0] rem_in [DIV_STAGES];
   logic [DIV_QUO_W-1:0] sh_ff  [DIV_STAGES];
   logic [DIV_QUO_W-1:0] sh_in  [DIV_STAGES];
   logic [DIV_DEN_W-1:0] den_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0] den_in [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [DIV_DEN_W-1:0] src_rem;
      logic [DIV_QUO_W-1:0] src_sh;
      logic [DIV_DEN_W-1:0] src_den;

      if (s == 0) begin : g_first
         assign src_rem = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_QUO_W]);
         assign src_sh  = num[DIV_QUO_W-1:0];
         assign src_den = den;
      end else begin : g_next
         assign src_rem = rem_ff[s-1];
         assign src_sh  = sh_ff[s-1];
         assign src_den = den_ff[s-1];
      end

      always_comb begin
         logic [DIV_DEN_W-1:0] rem;
         logic [DIV_QUO_W-1:0] sh;
         logic [DIV_DEN_W:0]   trial;
         logic                 ge;
         rem = src_rem;
         sh  = src_sh;
         for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {rem, sh[DIV_QUO_W-1]};
            ge    = (trial >= {1'b0, src_den});
            sh    = {sh[DIV_QUO_W-2:0], ge};
            rem   = ge ? DIV_DEN_W'(trial - {1'b0, src_den}) : trial[DIV_DEN_W-1:0];
         end
         rem_in[s] = rem;
         sh_in[s]  = sh;
         den_in[s] = src_den;
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in[s];
         sh_ff[s]  <= sh_in[s];
         den_ff[s] <= den_in[s];
      end
   end

   assign quo = sh_ff[DIV_STAGES-1];

endmodule

// ----- rtl/core/hsl_dark_pixel_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_dark_pixel_filter_core
// Per-pixel dark filter: rgb to hsl, inverted and compressed lightness,
// reduced saturation, back to rgb; the pixel passes untouched when disabled.
// ----------------------------------------------------------------------------
// One pixel is taken on every clock; busy never rises. Each item leaves on
// rsp_strobe in order, for one cycle only, since the receiver cannot stall.
// Its path runs through the input register, the operand register, the two
// six-stage dividers (three quotient bits per stage) for saturation and hue,
// the multiplier stages of the lightness and rgb rebuild and the output
// register. dark_enable is sampled when a pixel is taken and travels with it.
module hsl_dark_pixel_filter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hdpf_pkg::req_type req_pixel,
   output logic              rsp_strobe,
   output hdpf_pkg::rsp_type rsp_pixel,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata
);
   import hdpf_pkg::*;

   localparam int unsigned SIDE_DEPTH = 1 + DIV_STAGES + 6;
   localparam int unsigned DIV_OUT = DIV_STAGES;
   localparam int unsigned LAT = SIDE_DEPTH + 2;

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   localparam logic [1:0] MODE_RISE = 2'd0;
   localparam logic [1:0] MODE_Q    = 2'd1;
   localparam logic [1:0] MODE_FALL = 2'd2;
   localparam logic [1:0] MODE_P    = 2'd3;

   typedef struct packed {
      logic       en;
      req_type    pix;
      logic       achrom;
      logic       neg;
      logic [1:0] sector;
      logic [8:0] sum;
   } side_type;

   logic     dark_en_ff;
   logic     in_vld_ff;
   logic     in_en_ff;
   req_type  in_pix_ff;

   logic     vld_ff [SIDE_DEPTH];
   side_type sd_ff  [SIDE_DEPTH];
   side_type sd_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         dark_en_ff <= 1'b1;
         in_vld_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            dark_en_ff <= csr_wdata;
         end
         in_vld_ff <= start;
      end
      in_en_ff  <= dark_en_ff;
      in_pix_ff <= req_pixel;
   end

   // max, min, sector and divider operands
   logic [7:0]           mx, mn, d8, ha, hb, mag;
   logic [8:0]           sum9, den9;
   logic [DIV_NUM_W-1:0] snum_in, hnum_in, snum_ff, hnum_ff;
   logic [7:0]           sden_ff, hden_ff;

   always_comb begin
      mx = in_pix_ff.in_red;
      if (in_pix_ff.in_green > mx) mx = in_pix_ff.in_green;
      if (in_pix_ff.in_blue > mx)  mx = in_pix_ff.in_blue;
      mn = in_pix_ff.in_red;
      if (in_pix_ff.in_green < mn) mn = in_pix_ff.in_green;
      if (in_pix_ff.in_blue < mn)  mn = in_pix_ff.in_blue;
      sum9 = {1'b0, mx} + {1'b0, mn};
      d8   = mx - mn;
      den9 = (sum9 <= 9'd255) ? sum9 : 9'd510 - sum9;

      sd_in.en     = in_en_ff;
      sd_in.pix    = in_pix_ff;
      sd_in.achrom = (d8 == 8'd0);
      sd_in.sum    = sum9;
      if (mx == in_pix_ff.in_red) begin
         sd_in.sector = SECTOR_RED;
         ha = in_pix_ff.in_green;
         hb = in_pix_ff.in_blue;
      end else if (mx == in_pix_ff.in_green) begin
         sd_in.sector = SECTOR_GREEN;
         ha = in_pix_ff.in_blue;
         hb = in_pix_ff.in_red;
      end else begin
         sd_in.sector = SECTOR_BLUE;
         ha = in_pix_ff.in_red;
         hb = in_pix_ff.in_green;
      end
      sd_in.neg = (ha < hb);
      mag = sd_in.neg ? hb - ha : ha - hb;

      // value * 65536 + divisor / 2 for round to nearest
      snum_in = {d8, 9'd0, den9[7:1]};
      hnum_in = {mag, 9'd0, d8[7:1]};
   end

   always_ff @(posedge clock) begin
      snum_ff <= snum_in;
      hnum_ff <= hnum_in;
      sden_ff <= den9[7:0];
      hden_ff <= d8;
   end

   // side pipeline beside the dividers and multipliers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SIDE_DEPTH; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld_ff;
         for (int k = 1; k < SIDE_DEPTH; k++) vld_ff[k] <= vld_ff[k-1];
      end
      sd_ff[0] <= sd_in;
      for (int k = 1; k < SIDE_DEPTH; k++) sd_ff[k] <= sd_ff[k-1];
   end

   logic [DIV_QUO_W-1:0] squo, hquo;

   hdpf_divider u_sat_div (
      .clock (clock),
      .num   (snum_ff),
      .den   (sden_ff),
      .quo   (squo)
   );

   hdpf_divider u_hue_div (
      .clock (clock),
      .num   (hnum_ff),
      .den   (hden_ff),
      .quo   (hquo)
   );

   // e1: hue, saturation and lightness products
   side_type    sd1;
   logic [16:0] s_val, t_val;
   logic [18:0] base, h_in;
   logic [19:0] h_sum;
   logic [24:0] l_num;
   logic [18:0] e1_h_ff;
   logic [32:0] e1_snp_ff;
   logic [51:0] e1_lp_ff;

   always_comb begin
      sd1   = sd_ff[DIV_OUT];
      s_val = sd1.achrom ? 17'd0 : squo[16:0];
      t_val = hquo[16:0];
      case (sd1.sector)
         SECTOR_RED:   base = 19'd0;
         SECTOR_GREEN: base = H_TWO;
         SECTOR_BLUE:  base = H_FOUR;
         default:      base = 19'd0;
      endcase
      if (!sd1.neg) begin
         h_sum = {1'b0, base} + 20'(t_val);
         if (h_sum >= 20'(H_SIX)) h_sum = h_sum - 20'(H_SIX);
      end else if (base >= 19'(t_val)) begin
         h_sum = 20'(base) - 20'(t_val);
      end else begin
         h_sum = 20'(base) + 20'(H_SIX) - 20'(t_val);
      end
      h_in  = sd1.achrom ? 19'd0 : h_sum[18:0];
      l_num = {sd1.sum, 16'd0} + L_BIAS;
   end

   always_ff @(posedge clock) begin
      e1_h_ff   <= h_in;
      e1_snp_ff <= s_val * K_SAT;
      e1_lp_ff  <= l_num * L_RECIP;
   end

   // e2: round saturation, lightness inversion product
   logic [15:0] e2_sn_ff;
   logic [16:0] l_val;
   logic [18:0] e2_h_ff;
   logic [31:0] e2_lnp_ff;

   assign l_val = 17'(e1_lp_ff >> L_SHIFT);

   always_ff @(posedge clock) begin
      e2_h_ff   <= e1_h_ff;
      e2_sn_ff  <= 16'((e1_snp_ff + 33'(FX_HALF)) >> 16);
      e2_lnp_ff <= (FX_ONE - l_val) * K_SPAN;
   end

   // e3: new lightness and its product with saturation
   logic [16:0] ln_val;
   logic [16:0] e3_ln_ff;
   logic [15:0] e3_sn_ff;
   logic [18:0] e3_h_ff;
   logic [32:0] e3_lsp_ff;

   assign ln_val = 17'(K_BASE) + 17'((33'(e2_lnp_ff) + 33'(FX_HALF)) >> 16);

   always_ff @(posedge clock) begin
      e3_ln_ff  <= ln_val;
      e3_sn_ff  <= e2_sn_ff;
      e3_h_ff   <= e2_h_ff;
      e3_lsp_ff <= ln_val * e2_sn_ff;
   end

   // e4: q, p and per-channel hue
   logic [16:0] ls_val;
   logic [17:0] q_w, p_w;
   logic [16:0] e4_q_ff, e4_p_ff;
   logic [18:0] x_in [3];
   logic [18:0] e4_x_ff [3];
   logic [19:0] x_r, x_b;

   always_comb begin
      ls_val = 17'((e3_lsp_ff + 33'(FX_HALF)) >> 16);
      if (e3_ln_ff < FX_HALF) begin
         q_w = 18'(e3_ln_ff) + 18'(ls_val);
      end else begin
         q_w = 18'(e3_ln_ff) + 18'(e3_sn_ff) - 18'(ls_val);
      end
      if (q_w > 18'(FX_ONE)) q_w = 18'(FX_ONE);
      if (q_w < 18'(e3_ln_ff)) q_w = 18'(e3_ln_ff);
      p_w = {e3_ln_ff, 1'b0} - q_w;

      x_r = 20'(e3_h_ff) + 20'(H_TWO);
      if (x_r >= 20'(H_SIX)) x_r = x_r - 20'(H_SIX);
      x_b = 20'(e3_h_ff) + 20'(H_FOUR);
      if (x_b >= 20'(H_SIX)) x_b = x_b - 20'(H_SIX);
      x_in[0] = x_r[18:0];
      x_in[1] = e3_h_ff;
      x_in[2] = x_b[18:0];
   end

   always_ff @(posedge clock) begin
      e4_q_ff <= q_w[16:0];
      e4_p_ff <= p_w[16:0];
      for (int c = 0; c < 3; c++) e4_x_ff[c] <= x_in[c];
   end

   // e5: ramp products per channel
   logic [16:0] qp_diff;
   logic [1:0]  mode_in [3];
   logic [16:0] frac    [3];
   logic [1:0]  e5_mode_ff [3];
   logic [33:0] e5_prod_ff [3];
   logic [16:0] e5_q_ff, e5_p_ff;

   assign qp_diff = e4_q_ff - e4_p_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (e4_x_ff[c] < 19'(FX_ONE)) begin
            mode_in[c] = MODE_RISE;
            frac[c]    = e4_x_ff[c][16:0];
         end else if (e4_x_ff[c] < H_THREE) begin
            mode_in[c] = MODE_Q;
            frac[c]    = 17'd0;
         end else if (e4_x_ff[c] < H_FOUR) begin
            mode_in[c] = MODE_FALL;
            frac[c]    = 17'(H_FOUR - e4_x_ff[c]);
         end else begin
            mode_in[c] = MODE_P;
            frac[c]    = 17'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         e5_mode_ff[c] <= mode_in[c];
         e5_prod_ff[c] <= qp_diff * frac[c];
      end
      e5_q_ff <= e4_q_ff;
      e5_p_ff <= e4_p_ff;
   end

   // e6: channel level
   logic [17:0] v_w  [3];
   logic [16:0] e6_v_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (e5_mode_ff[c])
            MODE_RISE, MODE_FALL: v_w[c] = 18'(e5_p_ff)
               + 18'((e5_prod_ff[c] + 34'(FX_HALF)) >> 16);
            MODE_Q:  v_w[c] = 18'(e5_q_ff);
            MODE_P:  v_w[c] = 18'(e5_p_ff);
            default: v_w[c] = 18'(e5_p_ff);
         endcase
         if (v_w[c] > 18'(FX_ONE)) v_w[c] = 18'(FX_ONE);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) e6_v_ff[c] <= v_w[c][16:0];
   end

   // output register: back to 8 bits, or the untouched pixel
   side_type   sd6;
   logic [7:0] ch [3];
   logic       rsp_strobe_ff;
   rsp_type    rsp_pixel_ff;
   rsp_type    rsp_pixel_in;

   assign sd6 = sd_ff[SIDE_DEPTH-1];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ch[c] = 8'(((26'(e6_v_ff[c]) * 26'd255) + 26'(FX_HALF)) >> 16);
      end
      if (sd6.en) begin
         rsp_pixel_in.out_red   = ch[0];
         rsp_pixel_in.out_green = ch[1];
         rsp_pixel_in.out_blue  = ch[2];
      end else begin
         rsp_pixel_in.out_red   = sd6.pix.in_red;
         rsp_pixel_in.out_green = sd6.pix.in_green;
         rsp_pixel_in.out_blue  = sd6.pix.in_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vld_ff[SIDE_DEPTH-1];
      end
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_pixel  = rsp_pixel_ff;

   // every item taken leaves after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("item lost in pipeline");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("result without an item");

   a_bypass: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(dark_en_ff, LAT)) |->
         (rsp_pixel.out_red == $past(req_pixel.in_red, LAT)) &&
         (rsp_pixel.out_green == $past(req_pixel.in_green, LAT)) &&
         (rsp_pixel.out_blue == $past(req_pixel.in_blue, LAT)))
      else $error("bypass pixel altered");

   a_grey: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(dark_en_ff, LAT) &&
       $past(req_pixel.in_red == req_pixel.in_green, LAT) &&
       $past(req_pixel.in_green == req_pixel.in_blue, LAT)) |->
         (rsp_pixel.out_red == rsp_pixel.out_green) &&
         (rsp_pixel.out_green == rsp_pixel.out_blue))
      else $error("grey pixel gained color");

endmodule
